// ----- hdl/perfect_shuffle_order_counter_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion helpers for the perfect shuffle order counter
// Clocked, reset-qualified property wrappers used by the RTL.
// ---------------------------------------------------------------------------
`ifndef PERFECT_SHUFFLE_ORDER_COUNTER_ASSERT_SVH
`define PERFECT_SHUFFLE_ORDER_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PSOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/psoc_pkg.sv -----
// ---------------------------------------------------------------------------
// psoc_pkg
// Shared types and state codes for the perfect shuffle order counter.
// ---------------------------------------------------------------------------
`default_nettype none

package psoc_pkg;

    // Sequencer state
    typedef logic [0:0] t_state;

    localparam t_state ST_IDLE = 1'b0;
    localparam t_state ST_RUN  = 1'b1;

    // Fixed port field width
    localparam int FIELD_W = 9;

endpackage

`default_nettype wire

// ----- hdl/psoc_ram.sv -----
// ---------------------------------------------------------------------------
// psoc_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module psoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/perfect_shuffle_order_counter.sv -----
// ---------------------------------------------------------------------------
// perfect_shuffle_order_counter
// Counts the right-first perfect shuffles that return a deck to its order.
// ---------------------------------------------------------------------------
// A deck size is taken when start is high and busy is low; sizes above
// MAX_DECK are clamped to MAX_DECK. The deck lives in two RAMs used in
// ping-pong: each shuffle pass streams n reads from one RAM through the
// registered read port and writes the other, checking each written card
// against its position on the way. The first pass writes the shuffle
// indices directly, so no fill sweep is needed. Each pass issues one read
// per card through the single RAM read port, and a job runs at most
// MAX_DECK passes; no new size is taken until it ends. The result
// is shown for one cycle on o_done and must be captured then: there is no
// way to hold it off. busy stays high from acceptance until that cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module perfect_shuffle_order_counter #(
    parameter int MAX_DECK = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [8:0] i_deck_size,
    output logic            busy,
    output logic            o_done,
    output logic [8:0]      o_size_echo,
    output logic [8:0]      o_shuffle_count
);

    // Card index width, counter width and a width wide enough for both sides
    localparam int CW = $clog2(MAX_DECK);
    localparam int KW = CW + 1;
    localparam int IW = (KW > psoc_pkg::FIELD_W) ? KW : psoc_pkg::FIELD_W;

    psoc_pkg::t_state r_state, n_state;
    logic [KW-1:0]    r_n, n_n;          // clamped deck size
    logic [KW-1:0]    r_k, n_k;          // read issue position
    logic [KW-1:0]    r_cnt, n_cnt;      // passes done
    logic [CW-1:0]    r_wk, n_wk;        // write position, one behind
    logic [CW-1:0]    r_src, n_src;      // source index of the first pass
    logic             r_pv, n_pv;        // write stage holds a card
    logic             r_mis, n_mis;      // a card out of place this pass
    logic             r_first, n_first;  // first pass of the job
    logic             r_sel, n_sel;      // RAM read this pass
    logic             r_done, n_done;
    logic [KW-1:0]    r_out_n, n_out_n;
    logic [KW-1:0]    r_out_c, n_out_c;

    logic [CW-1:0]    l_kidx;
    logic [CW-1:0]    l_half;
    logic [KW-1:0]    l_sum;
    logic [CW-1:0]    l_rsrc;
    logic [CW-1:0]    l_rdata0, l_rdata1;
    logic [CW-1:0]    l_wdata;
    logic [IW-1:0]    l_req, l_clamp;
    logic [IW-1:0]    l_echo_w, l_cnt_w;
    logic [KW-1:0]    l_cnt_inc;
    logic             l_accept;

    // Shuffle source index for the position being issued
    always_comb begin
        l_kidx = r_k[CW-1:0];
        l_half = r_n[KW-1:1];
        l_sum  = {1'b0, l_half} + {1'b0, (l_kidx >> 1)};
        l_rsrc = l_kidx[0] ? (l_kidx >> 1) : l_sum[CW-1:0];
    end

    // Ping-pong deck storage
    psoc_ram #(.WIDTH(CW), .DEPTH(MAX_DECK)) u_deck0 (
        .i_clk   (i_clk),
        .i_we    (r_pv && r_sel),
        .i_waddr (r_wk),
        .i_wdata (l_wdata),
        .i_raddr (l_rsrc),
        .o_rdata (l_rdata0)
    );

    psoc_ram #(.WIDTH(CW), .DEPTH(MAX_DECK)) u_deck1 (
        .i_clk   (i_clk),
        .i_we    (r_pv && !r_sel),
        .i_waddr (r_wk),
        .i_wdata (l_wdata),
        .i_raddr (l_rsrc),
        .o_rdata (l_rdata1)
    );

    // Card written this cycle
    assign l_wdata = r_first ? r_src : (r_sel ? l_rdata1 : l_rdata0);

    // Input clamp
    assign l_accept = start && (r_state == psoc_pkg::ST_IDLE);
    assign l_req    = IW'(i_deck_size);
    assign l_clamp  = (l_req > IW'(MAX_DECK)) ? IW'(MAX_DECK) : l_req;
    assign l_cnt_inc = r_cnt + KW'(1);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_wk    = r_wk;
        n_src   = r_src;
        n_pv    = 1'b0;
        n_mis   = r_mis;
        n_first = r_first;
        n_sel   = r_sel;
        n_done  = 1'b0;
        n_out_n = r_out_n;
        n_out_c = r_out_c;
        case (r_state)
            psoc_pkg::ST_IDLE: begin
                if (l_accept) begin
                    n_state = psoc_pkg::ST_RUN;
                    n_n     = l_clamp[KW-1:0];
                    n_k     = '0;
                    n_cnt   = '0;
                    n_mis   = 1'b0;
                    n_first = 1'b1;
                    n_sel   = 1'b0;
                end
            end
            psoc_pkg::ST_RUN: begin
                // Check the card leaving the write stage
                if (r_pv && (l_wdata != r_wk)) begin
                    n_mis = 1'b1;
                end
                if (r_k < r_n) begin
                    // Issue the next read
                    n_k   = r_k + KW'(1);
                    n_pv  = 1'b1;
                    n_wk  = l_kidx;
                    n_src = l_rsrc;
                end else if (!r_pv) begin
                    // Pass complete and drained
                    if (!r_mis || (l_cnt_inc == KW'(MAX_DECK))) begin
                        n_state = psoc_pkg::ST_IDLE;
                        n_done  = 1'b1;
                        n_out_n = r_n;
                        n_out_c = l_cnt_inc;
                    end else begin
                        n_cnt   = l_cnt_inc;
                        n_k     = '0;
                        n_mis   = 1'b0;
                        n_first = 1'b0;
                        n_sel   = !r_sel;
                    end
                end
            end
            default: begin
                n_state = psoc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psoc_pkg::ST_IDLE;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_k     <= n_k;
        r_wk    <= n_wk;
        r_src   <= n_src;
        r_mis   <= n_mis;
        r_first <= n_first;
        r_sel   <= n_sel;
        r_out_n <= n_out_n;
        r_out_c <= n_out_c;
    end

    // Outputs
    assign l_echo_w        = IW'(r_out_n);
    assign l_cnt_w         = IW'(r_out_c);
    assign busy            = (r_state != psoc_pkg::ST_IDLE);
    assign o_done          = r_done;
    assign o_size_echo     = l_echo_w[psoc_pkg::FIELD_W-1:0];
    assign o_shuffle_count = l_cnt_w[psoc_pkg::FIELD_W-1:0];

`include "perfect_shuffle_order_counter_assert.svh"

    `PSOC_ASSERT_NEXT(a_accept_busy, l_accept, busy, "accepted size did not raise busy")
    `PSOC_ASSERT_NOW(a_done_count, o_done, r_out_c != '0, "result count of zero")
    `PSOC_ASSERT_NOW(a_wr_range, r_pv, KW'(r_wk) < r_n, "write beyond deck size")
    `PSOC_ASSERT_NOW(a_cnt_max, busy, r_cnt < KW'(MAX_DECK), "pass counter overran")
    `PSOC_ASSERT_NOW(a_done_idle, o_done, !busy, "result shown while busy")

endmodule

`default_nettype wire

// ----- verif/shuffle_order_checker.sv -----
// ---------------------------------------------------------------------------
// shuffle_order_checker
// Watches the command and result ports of the shuffle order counter, works
// out the shuffle count of every accepted deck size and compares each result
// beat against the oldest outstanding prediction, field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module shuffle_order_checker #(
    parameter int MAX_DECK = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic [psoc_pkg::FIELD_W-1:0] i_deck_size,
    input  wire logic                         o_done,
    input  wire logic [psoc_pkg::FIELD_W-1:0] o_size_echo,
    input  wire logic [psoc_pkg::FIELD_W-1:0] o_shuffle_count,
    output int                                o_mismatch_count,
    output int                                o_pending
);

    localparam int FIELD_W = psoc_pkg::FIELD_W;

    typedef struct packed {
        logic [FIELD_W-1:0] size_used;
        logic [FIELD_W-1:0] order;
    } t_deck_order;

    t_deck_order pending_orders[$];
    int          mismatches = 0;

    assign o_mismatch_count = mismatches;
    assign o_pending        = pending_orders.size();

    // Shuffle a scratch deck right-half-first until it is home again,
    // giving up after MAX_DECK passes; oversized requests are clamped
    function automatic t_deck_order predict_deck_order(input logic [FIELD_W-1:0] req);
        int unsigned cards;
        int unsigned half;
        int unsigned passes;
        int unsigned k;
        int          deck[MAX_DECK];
        int          shuffled[MAX_DECK];
        bit          home;
        t_deck_order res;
        cards  = (req > MAX_DECK) ? MAX_DECK : req;
        half   = cards / 2;
        passes = 0;
        for (k = 0; k < cards; k++) begin
            deck[k] = k;
        end
        do begin
            for (k = 0; k < cards; k++) begin
                shuffled[k] = k[0] ? deck[(k - 1) / 2] : deck[half + k / 2];
            end
            home = 1'b1;
            for (k = 0; k < cards; k++) begin
                deck[k] = shuffled[k];
                if (deck[k] != k) begin
                    home = 1'b0;
                end
            end
            passes++;
        end while (!home && passes < MAX_DECK);
        res.size_used = cards[FIELD_W-1:0];
        res.order     = passes[FIELD_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Result beat first, so a command taken on the same edge is never matched
    always @(posedge i_clk) begin
        t_deck_order want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_orders.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding (size %0d count %0d)",
                                              o_size_echo, o_shuffle_count));
                end else begin
                    want = pending_orders.pop_front();
                    if (o_size_echo !== want.size_used) begin
                        report_mismatch($sformatf("size_echo got %0d want %0d",
                                                  o_size_echo, want.size_used));
                    end
                    if (o_shuffle_count !== want.order) begin
                        report_mismatch($sformatf("shuffle_count for %0d got %0d want %0d",
                                                  want.size_used, o_shuffle_count, want.order));
                    end
                end
            end
            if (start && !busy) begin
                pending_orders.push_back(predict_deck_order(i_deck_size));
            end
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the perfect shuffle order counter.
// Directed deck sizes (empty, tiny, extremes, oversized) are followed by
// random sizes, mostly small, with random gaps between commands and one
// drain pause; the checker alongside does all prediction and comparison.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int FIELD_W        = psoc_pkg::FIELD_W;
    localparam int MAX_DECK       = 256;
    localparam int RANDOM_ITEMS   = 80;
    // Longest legal job is MAX_DECK passes over a full deck of MAX_DECK cards
    localparam int JOB_CYCLES     = MAX_DECK * (MAX_DECK + 2) + 1;
    localparam int WATCHDOG_LIMIT = 4 * JOB_CYCLES + 1000;
    localparam int TAIL_CYCLES    = 4 * (MAX_DECK + 2);

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic [FIELD_W-1:0] i_deck_size = '0;
    logic               busy;
    logic               o_done;
    logic [FIELD_W-1:0] o_size_echo;
    logic [FIELD_W-1:0] o_shuffle_count;

    int mismatch_count;
    int pending;
    int stall_cycles = 0;
    bit gaps_on      = 1'b1;

    always #5 i_clk = ~i_clk;

    perfect_shuffle_order_counter #(
        .MAX_DECK(MAX_DECK)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_deck_size    (i_deck_size),
        .busy           (busy),
        .o_done         (o_done),
        .o_size_echo    (o_size_echo),
        .o_shuffle_count(o_shuffle_count)
    );

    shuffle_order_checker #(
        .MAX_DECK(MAX_DECK)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_deck_size     (i_deck_size),
        .o_done          (o_done),
        .o_size_echo     (o_size_echo),
        .o_shuffle_count (o_shuffle_count),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending)
    );

    // Watchdog: cycles with neither a command nor a result beat
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Issue one deck size, with an optional random gap first; start is
    // left high on return so back-to-back commands never glitch it
    task automatic send_deck(input logic [FIELD_W-1:0] size);
        int gap;
        if (gaps_on && $urandom_range(99) < 11) begin
            gap = $urandom_range(1, 24);
            start       <= 1'b0;
            i_deck_size <= FIELD_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_deck_size <= size;
        do @(posedge i_clk); while (busy);
    endtask

    // Mostly small decks; a few large and oversized ones
    function automatic logic [FIELD_W-1:0] random_deck_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 88) begin
            return FIELD_W'($urandom_range(0, 63));
        end else if (pick < 96) begin
            return FIELD_W'($urandom_range(64, 160));
        end
        return FIELD_W'($urandom_range(161, 511));
    endfunction

    initial begin
        logic [FIELD_W-1:0] directed_sizes[$];
        int                 tail;
        // empty, single card, small even/odd, largest legal, oversized, bit patterns
        directed_sizes = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8,
                           9'd10, 9'd11, 9'd52, 9'd85, 9'd170, 9'd255, 9'd256,
                           9'd257, 9'd384, 9'd511, 9'd1};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_sizes[i]) begin
            send_deck(directed_sizes[i]);
        end

        // Hold off until every outstanding result is back
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gaps_on = (i < 30) || (i >= 70);
            send_deck(random_deck_size());
        end
        start <= 1'b0;

        // Drain, then watch a while longer for stray beats
        do @(posedge i_clk); while (pending != 0);
        tail = TAIL_CYCLES;
        repeat (tail) @(posedge i_clk);

        if (mismatch_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/psoc_pkg.sv
hdl/psoc_ram.sv
hdl/perfect_shuffle_order_counter.sv
verif/shuffle_order_checker.sv
verif/tb.sv
